// ===== hdl/aal_pkg.sv =====
// Shared widths, codes, pipeline control types and helpers for the affine active-list MAC.
package aal_pkg;

    localparam int LANES_DEF = 8;
    localparam int MAX_LANES = 8;

    localparam int ROW_W     = 16;
    localparam int WEIGHT_W  = 8;
    localparam int SAMPLE_W  = 16;
    localparam int BIAS_W    = 32;
    localparam int SCALE_W   = 8;
    localparam int VALUE_W   = 32;
    localparam int VIDX_W    = 3;
    localparam int SATCNT_W  = 32;
    localparam int POS_W     = 16;
    localparam int VCNT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int PROD1_W   = SAMPLE_W + WEIGHT_W;
    localparam int PROD2_W   = PROD1_W + SCALE_W + 1;
    // Bias plus 65535 full-scale products stays below 2^47.
    localparam int ACC_W     = 48;
    localparam int POP_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_COUNT = 2'd0,
        CFG_VECTOR_COUNT  = 2'd1,
        CFG_CHUNK_LENGTH  = 2'd2
    } t_cfg_idx;

    // Control that travels alongside one element through the lane pipeline.
    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      clamp;
        logic                      final_item;
        logic [VCNT_W-1:0]         n;
        logic [ROW_W-1:0]          row;
        logic signed [BIAS_W-1:0]  bias;
        logic [SCALE_W-1:0]        scale;
    } t_ctl;

    // Row completion handed to the result merger.
    typedef struct packed {
        logic                  capture;
        logic [ROW_W-1:0]      row;
        logic [VCNT_W-1:0]     n;
        logic [SATCNT_W-1:0]   total;
    } t_fin;

    function automatic logic [POP_W-1:0] popcount8(input logic [MAX_LANES-1:0] v);
        logic [POP_W-1:0] c;
        c = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            c = c + POP_W'(v[k]);
        end
        return c;
    endfunction

endpackage

// ===== hdl/aal_if.sv =====
// Channel interfaces: configuration writes, input elements and row results.
interface aal_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aal_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [aal_pkg::CFG_DAT_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

interface aal_in_if;
    logic                                valid;
    logic                                ready;
    logic [aal_pkg::ROW_W-1:0]           row_index;
    logic signed [aal_pkg::WEIGHT_W-1:0] weight;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_0;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_1;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_2;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_3;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_4;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_5;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_6;
    logic signed [aal_pkg::SAMPLE_W-1:0] sample_7;
    logic signed [aal_pkg::BIAS_W-1:0]   bias;
    logic [aal_pkg::SCALE_W-1:0]         scale;

    modport source (output valid, output row_index, output weight,
                    output sample_0, output sample_1, output sample_2, output sample_3,
                    output sample_4, output sample_5, output sample_6, output sample_7,
                    output bias, output scale, input ready);
    modport sink   (input valid, input row_index, input weight,
                    input sample_0, input sample_1, input sample_2, input sample_3,
                    input sample_4, input sample_5, input sample_6, input sample_7,
                    input bias, input scale, output ready);
endinterface

interface aal_out_if;
    logic                                valid;
    logic                                ready;
    logic [aal_pkg::ROW_W-1:0]           out_row;
    logic [aal_pkg::VIDX_W-1:0]          vector_index;
    logic signed [aal_pkg::VALUE_W-1:0]  value;
    logic                                clipped;
    logic [aal_pkg::SATCNT_W-1:0]        saturation_total;
    logic                                last;

    modport source (output valid, output out_row, output vector_index, output value,
                    output clipped, output saturation_total, output last, input ready);
    modport sink   (input valid, input out_row, input vector_index, input value,
                    input clipped, input saturation_total, input last, output ready);
endinterface

// ===== hdl/affine_active_list_int8_mac.sv =====
// Top level of the active-list affine MAC: configuration, sequencing, lanes and merger.
// Usage:
// - i_cfg writes element_count (0), vector_count (1) and chunk_length (2); writes are always
//   taken. Writing chunk_length holds off input while the position within the chunk is
//   recomputed bit-serially.
// - i_in takes one element of a row per transfer, one transfer per cycle while i_in.ready is
//   high. Row index, bias and scale are taken from the first element of a row.
// - Every lane runs a three-stage pipeline: sample times weight, times scale, then clamp and
//   accumulate. The final clamp of a row is read from the accumulators in the cycle after.
// - A row's results reach o_out through the lane stages, the merger snapshot and the output
//   register, one result per active vector, one per cycle, while o_out is not stalled.
// - Throughput: one element per cycle, but the last element of a row is held off until the
//   results of the previous row have all moved into the merger's output register and no
//   other row end is in flight.
// - When the receiver stalls, results wait in the merger and its output register; input keeps
//   flowing until the next row's last element.
// - Reset (synchronous, active low) restores element_count 1, vector_count 1, chunk_length
//   65535, clears the position, row, scale and saturation counter and drops all pending work.
module affine_active_list_int8_mac #(
    parameter int LANES = aal_pkg::LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aal_cfg_if.sink     i_cfg,
    aal_in_if.sink      i_in,
    aal_out_if.source   o_out
);
    localparam int PW = aal_pkg::POS_W;
    localparam int NW = aal_pkg::VCNT_W;
    localparam int ML = aal_pkg::MAX_LANES;

    // Configuration
    logic [PW-1:0]  r_elem_cnt;
    logic [NW-1:0]  r_vec_cnt;
    logic [PW-1:0]  r_chunk_len;

    // Row sequencing
    logic [PW-1:0]                r_pos;
    logic [PW-1:0]                r_cpos;
    logic [aal_pkg::ROW_W-1:0]    r_row;
    logic [aal_pkg::SCALE_W-1:0]  r_scale;
    logic [aal_pkg::SATCNT_W-1:0] r_sat_cnt;

    aal_pkg::t_ctl r_c1;
    aal_pkg::t_ctl r_c2;
    aal_pkg::t_ctl r_c3;
    aal_pkg::t_ctl w_c0;
    aal_pkg::t_fin w_fin;

    logic            w_cfg_wr;
    logic            w_accept;
    logic [PW-1:0]   w_pos_inc;
    logic [PW-1:0]   w_total;
    logic            w_first;
    logic            w_will_final;
    logic            w_final_free;
    logic [NW-1:0]   w_n;
    logic [PW-1:0]   w_cpos_inc;

    logic            w_rem_busy;
    logic            w_rem_done;
    logic [PW-1:0]   w_rem_result;
    logic            w_merge_busy;
    logic            w_cap;

    logic signed [aal_pkg::SAMPLE_W-1:0] w_samples [ML];
    logic signed [aal_pkg::VALUE_W-1:0]  w_values  [LANES];
    logic [LANES-1:0]                    w_hits;
    logic [LANES-1:0]                    w_fin_hits;
    logic [LANES-1:0]                    w_chunk_hits;
    logic [aal_pkg::POP_W-1:0]           w_fin_pop;
    logic [aal_pkg::POP_W-1:0]           w_chunk_pop;

    assign w_samples[0] = i_in.sample_0;
    assign w_samples[1] = i_in.sample_1;
    assign w_samples[2] = i_in.sample_2;
    assign w_samples[3] = i_in.sample_3;
    assign w_samples[4] = i_in.sample_4;
    assign w_samples[5] = i_in.sample_5;
    assign w_samples[6] = i_in.sample_6;
    assign w_samples[7] = i_in.sample_7;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt  <= PW'(1);
            r_vec_cnt   <= NW'(1);
            r_chunk_len <= '1;
        end else if (w_cfg_wr) begin
            unique case (aal_pkg::t_cfg_idx'(i_cfg.reg_index))
                aal_pkg::CFG_ELEMENT_COUNT: r_elem_cnt  <= i_cfg.wr_data[PW-1:0];
                aal_pkg::CFG_VECTOR_COUNT:  r_vec_cnt   <= i_cfg.wr_data[NW-1:0];
                aal_pkg::CFG_CHUNK_LENGTH:  r_chunk_len <= i_cfg.wr_data[PW-1:0];
                default: ;
            endcase
        end
    end

    aal_rem u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_wr && (i_cfg.reg_index == aal_pkg::CFG_CHUNK_LENGTH)),
        .i_num    (r_pos),
        .i_den    (i_cfg.wr_data[PW-1:0]),
        .o_busy   (w_rem_busy),
        .o_done   (w_rem_done),
        .o_result (w_rem_result)
    );

    always_comb begin
        w_total      = (r_elem_cnt == '0) ? PW'(1) : r_elem_cnt;
        w_pos_inc    = r_pos + PW'(1);
        w_first      = (r_pos == '0);
        w_will_final = (w_pos_inc == '0) || (w_pos_inc >= w_total);
        w_cpos_inc   = r_cpos + PW'(1);
        if (r_vec_cnt == '0) begin
            w_n = NW'(1);
        end else if (r_vec_cnt > NW'(LANES)) begin
            w_n = NW'(LANES);
        end else begin
            w_n = r_vec_cnt;
        end
        // A row end may enter only when the merger is sure to be free on arrival.
        w_final_free = !(r_c1.valid && r_c1.final_item) && !(r_c2.valid && r_c2.final_item)
                    && !(r_c3.valid && r_c3.final_item) && !w_merge_busy;
    end

    assign i_in.ready = !w_rem_busy && !w_cfg_wr && (!w_will_final || w_final_free);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_c0.valid      = w_accept;
        w_c0.first      = w_first;
        w_c0.clamp      = !w_first && (r_chunk_len != '0) && (r_cpos == '0);
        w_c0.final_item = w_will_final;
        w_c0.n          = w_n;
        w_c0.row        = w_first ? i_in.row_index : r_row;
        w_c0.bias       = i_in.bias;
        w_c0.scale      = w_first ? i_in.scale : r_scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cpos  <= '0;
            r_row   <= '0;
            r_scale <= '0;
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
        end else begin
            if (w_rem_done) begin
                r_cpos <= w_rem_result;
            end else if (w_accept) begin
                if (w_will_final) begin
                    r_cpos <= '0;
                end else begin
                    r_cpos <= ({1'b0, w_cpos_inc} == {1'b0, r_chunk_len}) ? '0 : w_cpos_inc;
                end
            end
            if (w_accept) begin
                r_pos <= w_will_final ? '0 : w_pos_inc;
                if (w_first) begin
                    r_row   <= i_in.row_index;
                    r_scale <= i_in.scale;
                end
            end
            r_c1 <= w_c0;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        aal_lane u_lane (
            .i_clk       (i_clk),
            .i_sample    (w_samples[k]),
            .i_weight    (i_in.weight),
            .i_scale     (r_c1.scale),
            .i_ctl       (r_c2),
            .i_en        (r_c2.n > NW'(k)),
            .o_value     (w_values[k]),
            .o_hit       (w_hits[k]),
            .o_chunk_hit (w_chunk_hits[k])
        );
        assign w_fin_hits[k] = w_cap && w_hits[k] && (r_c3.n > NW'(k));
    end

    assign w_cap       = r_c3.valid && r_c3.final_item;
    assign w_fin_pop   = aal_pkg::popcount8(ML'(w_fin_hits));
    assign w_chunk_pop = aal_pkg::popcount8(ML'(w_chunk_hits));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_cnt <= '0;
        end else begin
            r_sat_cnt <= r_sat_cnt + aal_pkg::SATCNT_W'(w_fin_pop)
                                   + aal_pkg::SATCNT_W'(w_chunk_pop);
        end
    end

    always_comb begin
        w_fin.capture = w_cap;
        w_fin.row     = r_c3.row;
        w_fin.n       = r_c3.n;
        w_fin.total   = r_sat_cnt + aal_pkg::SATCNT_W'(w_fin_pop);
    end

    aal_merge #(.LANES(LANES)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fin    (w_fin),
        .i_values (w_values),
        .i_hits   (w_fin_hits),
        .o_out    (o_out),
        .o_busy   (w_merge_busy)
    );
endmodule

// ===== hdl/aal_rem.sv =====
// Bit-serial remainder unit: element position modulo a newly written chunk length.
module aal_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [aal_pkg::POS_W-1:0]    i_num,
    input  logic [aal_pkg::POS_W-1:0]    i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [aal_pkg::POS_W-1:0]    o_result
);
    localparam int W   = aal_pkg::POS_W;
    localparam int CW  = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_den;
    logic [W:0]    r_rem;
    logic [W:0]    w_trial;
    logic [W:0]    n_rem;

    // Remainder stays below the divisor, so the shifted trial fits in W+1 bits.
    always_comb begin
        w_trial = {r_rem[W-1:0], r_num[W-1]};
        n_rem   = (w_trial >= {1'b0, r_den}) ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy   = r_busy | r_done;
    assign o_done   = r_done;
    assign o_result = r_rem[W-1:0];
endmodule

// ===== hdl/aal_lane.sv =====
// One accumulator lane: two multiply stages, then clamp-and-accumulate.
module aal_lane (
    input  logic                                i_clk,
    input  logic signed [aal_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [aal_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [aal_pkg::SCALE_W-1:0]         i_scale,
    input  aal_pkg::t_ctl                       i_ctl,
    input  logic                                i_en,
    output logic signed [aal_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_hit,
    output logic                                o_chunk_hit
);
    localparam int AW = aal_pkg::ACC_W;
    localparam int VW = aal_pkg::VALUE_W;
    localparam int P1 = aal_pkg::PROD1_W;
    localparam int P2 = aal_pkg::PROD2_W;
    localparam int BW = aal_pkg::BIAS_W;

    logic signed [P1-1:0] r_prod1;
    logic signed [P2-1:0] r_prod2;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [AW-1:0] w_base;
    logic signed [AW-1:0] w_addend;
    logic signed [VW-1:0] w_sat;
    logic                 w_oor;

    always_comb begin
        w_oor = (r_acc[AW-1:VW-1] != {(AW-VW+1){r_acc[AW-1]}});
        if (!w_oor) begin
            w_sat = r_acc[VW-1:0];
        end else if (r_acc[AW-1]) begin
            w_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VW-1){1'b1}}};
        end

        if (i_ctl.first) begin
            w_base = {{(AW-BW){i_ctl.bias[BW-1]}}, i_ctl.bias};
        end else if (i_ctl.clamp && i_en) begin
            w_base = {{(AW-VW){w_sat[VW-1]}}, w_sat};
        end else begin
            w_base = r_acc;
        end
        w_addend = i_en ? {{(AW-P2){r_prod2[P2-1]}}, r_prod2} : '0;
        n_acc    = w_base + w_addend;
    end

    always_ff @(posedge i_clk) begin
        r_prod1 <= i_sample * i_weight;
        r_prod2 <= r_prod1 * $signed({1'b0, i_scale});
        if (i_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_value     = w_sat;
    assign o_hit       = w_oor;
    assign o_chunk_hit = i_ctl.valid & i_ctl.clamp & i_en & w_oor;
endmodule

// ===== hdl/aal_merge.sv =====
// Result merger: snapshots the finished lanes and issues one result per vector.
module aal_merge #(
    parameter int LANES = aal_pkg::LANES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  aal_pkg::t_fin                      i_fin,
    input  logic signed [aal_pkg::VALUE_W-1:0] i_values [LANES],
    input  logic [LANES-1:0]                   i_hits,
    aal_out_if.source                          o_out,
    output logic                               o_busy
);
    localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NW = aal_pkg::VCNT_W;

    logic signed [aal_pkg::VALUE_W-1:0] r_vals [LANES];
    logic [LANES-1:0]                   r_hits;
    logic [aal_pkg::ROW_W-1:0]          r_row;
    logic [NW-1:0]                      r_n;
    logic [aal_pkg::SATCNT_W-1:0]       r_total;
    logic                               r_busy;
    logic [IW-1:0]                      r_idx;

    logic                               r_ovalid;
    logic [aal_pkg::ROW_W-1:0]          r_orow;
    logic [aal_pkg::VIDX_W-1:0]         r_ovidx;
    logic signed [aal_pkg::VALUE_W-1:0] r_ovalue;
    logic                               r_oclip;
    logic [aal_pkg::SATCNT_W-1:0]       r_ototal;
    logic                               r_olast;

    logic w_load;
    logic w_is_last;

    assign w_load    = r_busy && (!r_ovalid || o_out.ready);
    assign w_is_last = ((NW'(r_idx) + NW'(1)) == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_fin.capture) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_load) begin
                r_idx <= r_idx + IW'(1);
                if (w_is_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin.capture) begin
            r_vals  <= i_values;
            r_hits  <= i_hits;
            r_row   <= i_fin.row;
            r_n     <= i_fin.n;
            r_total <= i_fin.total;
        end
        if (w_load) begin
            r_orow   <= r_row;
            r_ovidx  <= aal_pkg::VIDX_W'(r_idx);
            r_ovalue <= r_vals[r_idx];
            r_oclip  <= r_hits[r_idx];
            r_ototal <= r_total;
            r_olast  <= w_is_last;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.out_row          = r_orow;
    assign o_out.vector_index     = r_ovidx;
    assign o_out.value            = r_ovalue;
    assign o_out.clipped          = r_oclip;
    assign o_out.saturation_total = r_ototal;
    assign o_out.last             = r_olast;
    assign o_busy                 = r_busy;
endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the active-list affine MAC: directed rows, then random rows under stalls.
`timescale 1ns / 1ps

module tb_top;
    import aal_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 30;
    // Index 3 decodes to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint I32_MIN = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic [ROW_W-1:0]           row;
        logic signed [WEIGHT_W-1:0] weight;
        logic signed [SAMPLE_W-1:0] smp [MAX_LANES];
        logic signed [BIAS_W-1:0]   bias;
        logic [SCALE_W-1:0]         scale;
    } element_t;

    typedef struct {
        logic [ROW_W-1:0]          row;
        logic [VIDX_W-1:0]         vidx;
        logic signed [VALUE_W-1:0] value;
        logic                      clipped;
        logic [SATCNT_W-1:0]       sat_total;
        logic                      last;
    } lane_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aal_cfg_if cfg_ch();
    aal_in_if  in_ch();
    aal_out_if out_ch();

    affine_active_list_int8_mac dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    element_t     pending_elems[$];
    lane_result_t lane_results[$];

    // Mirror of the configuration registers and of the row state.
    logic [CFG_DAT_W-1:0] mir_elems;
    logic [VCNT_W-1:0]    mir_vecs;
    logic [CFG_DAT_W-1:0] mir_chunk;
    longint               lane_acc [MAX_LANES];
    logic [POS_W-1:0]     row_pos;
    logic [ROW_W-1:0]     row_latched;
    logic [SCALE_W-1:0]   scale_latched;
    logic [SATCNT_W-1:0]  clamp_events;

    int errors       = 0;
    int elems_taken  = 0;
    int results_seen = 0;
    int rows_done    = 0;
    int phase_count  = 0;
    int cycles       = 0;
    int in_gap       = 0;
    int rx_gap       = 0;
    bit in_taken     = 1'b0;
    bit cfg_taken    = 1'b0;
    bit idle_on      = 1'b1;
    bit rx_hold      = 1'b0;
    bit rx_hold_go   = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic bit saturate_lane(input int k);
        bit hit;
        hit = 1'b0;
        if (lane_acc[k] > I32_MAX) begin
            lane_acc[k] = I32_MAX;
            hit = 1'b1;
        end else if (lane_acc[k] < I32_MIN) begin
            lane_acc[k] = I32_MIN;
            hit = 1'b1;
        end
        if (hit) begin
            clamp_events = clamp_events + 1'b1;
        end
        return hit;
    endfunction

    // Adds one element to every active lane and queues the row's results when it closes.
    task automatic accumulate_element(input element_t e);
        int n;
        int total;
        bit hit [MAX_LANES];
        lane_result_t r;
        n = (mir_vecs == 0) ? 1 : ((mir_vecs > MAX_LANES) ? MAX_LANES : int'(mir_vecs));
        total = (mir_elems == 0) ? 1 : int'(mir_elems);
        if (row_pos == 0) begin
            row_latched   = e.row;
            scale_latched = e.scale;
            for (int k = 0; k < MAX_LANES; k++) begin
                lane_acc[k] = longint'(e.bias);
            end
        end else if (mir_chunk != 0 && (row_pos % mir_chunk) == 0) begin
            for (int k = 0; k < n; k++) begin
                void'(saturate_lane(k));
            end
        end
        for (int k = 0; k < n; k++) begin
            lane_acc[k] += longint'(e.smp[k]) * longint'(e.weight) * longint'(scale_latched);
        end
        row_pos = row_pos + 1'b1;
        if (row_pos != 0 && row_pos < total) begin
            return;
        end
        row_pos = '0;
        for (int k = 0; k < n; k++) begin
            hit[k] = saturate_lane(k);
        end
        for (int k = 0; k < n; k++) begin
            r.row       = row_latched;
            r.vidx      = VIDX_W'(k);
            r.value     = lane_acc[k][VALUE_W-1:0];
            r.clipped   = hit[k];
            r.sat_total = clamp_events;
            r.last      = (k == n - 1);
            lane_results.push_back(r);
        end
        rows_done++;
    endtask

    // Monitor: mirrors register writes, checks results and predicts from accepted elements.
    always @(posedge i_clk) begin
        lane_result_t got;
        lane_result_t want;
        element_t e;
        in_taken  <= i_rst_n && in_ch.valid && in_ch.ready;
        cfg_taken <= i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.reg_index)
                CFG_ELEMENT_COUNT: mir_elems = cfg_ch.wr_data;
                CFG_VECTOR_COUNT:  mir_vecs  = cfg_ch.wr_data[VCNT_W-1:0];
                CFG_CHUNK_LENGTH:  mir_chunk = cfg_ch.wr_data;
                default: ;
            endcase
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.row       = out_ch.out_row;
            got.vidx      = out_ch.vector_index;
            got.value     = out_ch.value;
            got.clipped   = out_ch.clipped;
            got.sat_total = out_ch.saturation_total;
            got.last      = out_ch.last;
            results_seen++;
            if (lane_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: row %0d vector %0d value %0d",
                                          got.row, got.vidx, got.value));
            end else begin
                want = lane_results.pop_front();
                if (got.row !== want.row || got.vidx !== want.vidx ||
                    got.value !== want.value || got.clipped !== want.clipped ||
                    got.sat_total !== want.sat_total || got.last !== want.last) begin
                    report_mismatch({
                        $sformatf("got/exp row %0d/%0d vec %0d/%0d value %0d/%0d",
                                  got.row, want.row, got.vidx, want.vidx,
                                  got.value, want.value),
                        $sformatf(" clip %0b/%0b sat %0d/%0d last %0b/%0b",
                                  got.clipped, want.clipped, got.sat_total, want.sat_total,
                                  got.last, want.last)});
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            e.row    = in_ch.row_index;
            e.weight = in_ch.weight;
            e.smp[0] = in_ch.sample_0;
            e.smp[1] = in_ch.sample_1;
            e.smp[2] = in_ch.sample_2;
            e.smp[3] = in_ch.sample_3;
            e.smp[4] = in_ch.sample_4;
            e.smp[5] = in_ch.sample_5;
            e.smp[6] = in_ch.sample_6;
            e.smp[7] = in_ch.sample_7;
            e.bias   = in_ch.bias;
            e.scale  = in_ch.scale;
            elems_taken++;
            accumulate_element(e);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, lane_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Element driver: presents the next pending element once the current one has transferred.
    always @(negedge i_clk) begin
        element_t e;
        if (!in_ch.valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_elems.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 17);
                in_ch.valid <= 1'b0;
            end else if (pending_elems.size() != 0) begin
                e = pending_elems.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.row_index <= e.row;
                in_ch.weight    <= e.weight;
                in_ch.sample_0  <= e.smp[0];
                in_ch.sample_1  <= e.smp[1];
                in_ch.sample_2  <= e.smp[2];
                in_ch.sample_3  <= e.smp[3];
                in_ch.sample_4  <= e.smp[4];
                in_ch.sample_5  <= e.smp[5];
                in_ch.sample_6  <= e.smp[6];
                in_ch.sample_7  <= e.smp[7];
                in_ch.bias      <= e.bias;
                in_ch.scale     <= e.scale;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stall bursts and one long hold-off.
    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            rx_gap--;
            out_ch.ready <= 1'b0;
        end else if (rx_hold) begin
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 17);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        wait (rx_hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] elems, input logic [CFG_DAT_W-1:0] vecs,
                             input logic [CFG_DAT_W-1:0] chunk);
        write_reg(CFG_ELEMENT_COUNT, elems);
        write_reg(CFG_VECTOR_COUNT, vecs);
        write_reg(CFG_CHUNK_LENGTH, chunk);
        phase_count++;
    endtask

    // Returns once nothing is pending or expected, then lets any partial-row work drain.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_elems.size() != 0 || in_ch.valid || lane_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return 8'h80;
            1:       return 8'h7F;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 1 << 24);
            3:       return 32'h8000_0000 + $urandom_range(0, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return SCALE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic element_t make_elem(input logic [ROW_W-1:0] row,
                                           input logic [WEIGHT_W-1:0] weight,
                                           input logic [SAMPLE_W-1:0] smp,
                                           input logic [BIAS_W-1:0] bias,
                                           input logic [SCALE_W-1:0] scale);
        element_t e;
        e.row    = row;
        e.weight = weight;
        e.bias   = bias;
        e.scale  = scale;
        for (int k = 0; k < MAX_LANES; k++) begin
            e.smp[k] = smp;
        end
        return e;
    endfunction

    // Queues rows of row_len elements; some later elements carry a foreign header to be ignored.
    task automatic queue_rows(input int n_items, input int row_len);
        element_t e;
        int pos;
        pos = 0;
        for (int i = 0; i < n_items; i++) begin
            if (pos == 0 || $urandom_range(0, 3) == 0) begin
                e.row   = ROW_W'($urandom);
                e.bias  = pick_bias();
                e.scale = pick_scale();
            end
            e.weight = pick_weight();
            for (int k = 0; k < MAX_LANES; k++) begin
                e.smp[k] = pick_sample();
            end
            pending_elems.push_back(e);
            pos = (pos + 1) % row_len;
        end
    endtask

    initial begin
        element_t e;
        int n_el;
        int n_vec;
        int n_chunk;

        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = CFG_ELEMENT_COUNT;
        cfg_ch.wr_data   = '0;
        in_ch.valid      = 1'b0;
        in_ch.row_index  = '0;
        in_ch.weight     = '0;
        in_ch.sample_0   = '0;
        in_ch.sample_1   = '0;
        in_ch.sample_2   = '0;
        in_ch.sample_3   = '0;
        in_ch.sample_4   = '0;
        in_ch.sample_5   = '0;
        in_ch.sample_6   = '0;
        in_ch.sample_7   = '0;
        in_ch.bias       = '0;
        in_ch.scale      = '0;
        out_ch.ready     = 1'b0;
        mir_elems        = 16'd1;
        mir_vecs         = 4'd1;
        mir_chunk        = 16'hFFFF;
        row_pos          = '0;
        row_latched      = '0;
        scale_latched    = '0;
        clamp_events     = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            lane_acc[k] = 0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single-element rows on one vector, clamping only at row end.
        pending_elems.push_back(make_elem(16'hFFFF, 8'h80, 16'h8000, 32'h7FFF_FFFF, 8'hFF));
        pending_elems.push_back(make_elem(16'h0000, 8'h7F, 16'h7FFF, 32'h8000_0000, 8'h00));
        pending_elems.push_back(make_elem(16'h5A5A, 8'h80, 16'h7FFF, 32'h8000_0000, 8'hFF));
        wait_idle();

        // Clamp before every element after the first; later headers differ and must be ignored.
        configure(16'd3, 16'd8, 16'd1);
        e = make_elem(16'h1234, 8'h7F, 16'h7FFF, 32'h7FFF_FFF0, 8'hFF);
        for (int k = 4; k < MAX_LANES; k++) begin
            e.smp[k] = 16'h8000;
        end
        pending_elems.push_back(e);
        pending_elems.push_back(make_elem(16'hBEEF, 8'h80, 16'h7FFF, 32'h0000_0000, 8'h01));
        pending_elems.push_back(make_elem(16'h0F0F, 8'h7F, 16'h7FFF, 32'h8000_0000, 8'h00));
        queue_rows(3, 3);
        wait_idle();

        // Zero element count, zero vector count and zero chunk length.
        configure(16'd0, 16'd0, 16'd0);
        pending_elems.push_back(make_elem(16'h8001, 8'h7F, 16'h7FFF, 32'h7FFF_FFFF, 8'hFF));
        queue_rows(1, 1);
        wait_idle();

        // A vector count above the lane count acts as all lanes.
        write_reg(CFG_ELEMENT_COUNT, 16'd2);
        write_reg(CFG_VECTOR_COUNT, 16'hFFFF);
        phase_count++;
        e = make_elem(16'h00FF, 8'h7F, 16'h7FFF, 32'h7FFF_0000, 8'hFF);
        for (int k = 4; k < MAX_LANES; k++) begin
            e.smp[k] = 16'h8000;
        end
        pending_elems.push_back(e);
        pending_elems.push_back(e);
        wait_idle();

        // Longest row length with a partial row, then the element count drops below the position mid-row.
        configure(16'hFFFF, 16'd5, 16'd2);
        write_reg(CFG_SPARE, 16'hFFFF);
        queue_rows(4, 65535);
        wait_idle();
        write_reg(CFG_ELEMENT_COUNT, 16'd3);
        phase_count++;
        queue_rows(1, 1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_on = (p < RAND_PHASES - 2);
            case ($urandom_range(0, 9))
                0:       n_el = 0;
                1, 2, 3, 4, 5: n_el = $urandom_range(1, 4);
                6, 7, 8: n_el = $urandom_range(5, 12);
                default: n_el = $urandom_range(13, 40);
            endcase
            n_vec = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0:       n_chunk = 0;
                1:       n_chunk = 65535;
                2:       n_chunk = 1;
                default: n_chunk = $urandom_range(1, 8);
            endcase
            if (p == 2) begin
                // Short rows on all lanes while the receiver holds off: the block must back up.
                n_el  = 1;
                n_vec = 8;
            end
            configure(CFG_DAT_W'(n_el), CFG_DAT_W'(n_vec), CFG_DAT_W'(n_chunk));
            if (p == 2) begin
                rx_hold_go = 1'b1;
            end
            queue_rows(PHASE_ITEMS, (n_el == 0) ? 1 : n_el);
            wait_idle();
        end

        $display("Sent %0d elements over %0d register settings; %0d rows closed, %0d results seen.",
                 elems_taken, phase_count, rows_done, results_seen);
        $display("Clamp events predicted: %0d; a long output hold-off backed up the input.",
                 clamp_events);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== affine_active_list_int8_mac.f =====
hdl/aal_pkg.sv
hdl/aal_if.sv
hdl/aal_rem.sv
hdl/aal_lane.sv
hdl/aal_merge.sv
hdl/affine_active_list_int8_mac.sv
dv/tb_top.sv
